[design/sli_pkg.sv]
package sli_pkg;
   localparam int unsigned COORD_WIDTH_DEF = 32;
   localparam int unsigned FRAC_BITS_DEF   = 16;
   localparam int unsigned INDEX_WIDTH_DEF = 16;
   localparam int unsigned CSR_ADDR_WIDTH  = 2;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      REG_START_X = 2'd0,
      REG_START_Y = 2'd1,
      REG_END_X   = 2'd2,
      REG_END_Y   = 2'd3
   } csr_index_type;
endpackage

[design/sli_core.sv]
module sli_core #(
   parameter int unsigned COORD_WIDTH = sli_pkg::COORD_WIDTH_DEF,
   parameter int unsigned FRAC_BITS   = sli_pkg::FRAC_BITS_DEF,
   parameter int unsigned INDEX_WIDTH = sli_pkg::INDEX_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic        [INDEX_WIDTH-1:0] in_index,
   input  logic signed [COORD_WIDTH-1:0] in_x0,
   input  logic signed [COORD_WIDTH-1:0] in_y0,
   input  logic signed [COORD_WIDTH-1:0] in_x1,
   input  logic signed [COORD_WIDTH-1:0] in_y1,
   input  logic signed [COORD_WIDTH-1:0] q_x0,
   input  logic signed [COORD_WIDTH-1:0] q_y0,
   input  logic signed [COORD_WIDTH-1:0] q_x1,
   input  logic signed [COORD_WIDTH-1:0] q_y1,
   output logic                          out_valid,
   output logic                          out_hit,
   output logic        [INDEX_WIDTH-1:0] out_index,
   output logic          [FRAC_BITS:0]   out_fraction,
   output logic signed [COORD_WIDTH-1:0] out_x,
   output logic signed [COORD_WIDTH-1:0] out_y
);
   import sli_pkg::*;

   localparam int unsigned DW = COORD_WIDTH + 1;
   localparam int unsigned PW = 2 * DW;
   localparam int unsigned NW = PW + 1;
   localparam int unsigned LW = FRAC_BITS + 1 + DW;
   localparam int unsigned DIV_STAGES = FRAC_BITS;
   localparam int unsigned TOTAL = DIV_STAGES + 6;
   localparam logic signed [DW-1:0] VERT_LIMIT =
      DW'(((64'd1 << FRAC_BITS) + 64'd9999) / 64'd10000);

   // stage valid bits
   logic [TOTAL-1:0] vld_ff, vld_in;
   always_comb begin
      vld_in = vld_ff;
      if (advance) begin
         vld_in = {vld_ff[TOTAL-2:0], in_valid};
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: differences and box test
   logic signed [DW-1:0] dxa_ff, dya_ff, dxb_ff, dyb_ff, wx_ff, wy_ff;
   logic signed [COORD_WIDTH-1:0] bx_s1_ff, by_s1_ff;
   logic [INDEX_WIDTH-1:0] idx_s1_ff;
   logic apart_s1_ff, vert_s1_ff;
   logic signed [COORD_WIDTH-1:0] axmin, axmax, aymin, aymax, bxmin, bxmax, bymin, bymax;
   logic signed [DW-1:0] dxa_in;
   always_comb begin
      axmin = (q_x0 < q_x1) ? q_x0 : q_x1;
      axmax = (q_x0 < q_x1) ? q_x1 : q_x0;
      aymin = (q_y0 < q_y1) ? q_y0 : q_y1;
      aymax = (q_y0 < q_y1) ? q_y1 : q_y0;
      bxmin = (in_x0 < in_x1) ? in_x0 : in_x1;
      bxmax = (in_x0 < in_x1) ? in_x1 : in_x0;
      bymin = (in_y0 < in_y1) ? in_y0 : in_y1;
      bymax = (in_y0 < in_y1) ? in_y1 : in_y0;
      dxa_in = DW'(q_x1) - DW'(q_x0);
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         dxa_ff <= dxa_in;
         dya_ff <= DW'(q_y1) - DW'(q_y0);
         dxb_ff <= DW'(in_x1) - DW'(in_x0);
         dyb_ff <= DW'(in_y1) - DW'(in_y0);
         wx_ff  <= DW'(in_x0) - DW'(q_x0);
         wy_ff  <= DW'(in_y0) - DW'(q_y0);
         bx_s1_ff <= in_x0;
         by_s1_ff <= in_y0;
         idx_s1_ff <= in_index;
         apart_s1_ff <= (bxmin > axmax) || (bxmax < axmin) ||
                        (bymin > aymax) || (bymax < aymin);
         vert_s1_ff <= (dxa_in > -VERT_LIMIT) && (dxa_in < VERT_LIMIT);
      end
   end

   // stage 2: products
   logic signed [PW-1:0] p_ab_ff, p_ba_ff, p_wa_ff, p_ya_ff, p_wb_ff, p_yb_ff;
   logic signed [DW-1:0] wx_s2_ff, dxb_s2_ff, dyb_s2_ff;
   logic signed [COORD_WIDTH-1:0] bx_s2_ff, by_s2_ff;
   logic [INDEX_WIDTH-1:0] idx_s2_ff;
   logic apart_s2_ff, vert_s2_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         p_ab_ff <= PW'(dxa_ff) * PW'(dyb_ff);
         p_ba_ff <= PW'(dya_ff) * PW'(dxb_ff);
         p_wa_ff <= PW'(wx_ff) * PW'(dya_ff);
         p_ya_ff <= PW'(wy_ff) * PW'(dxa_ff);
         p_wb_ff <= PW'(wx_ff) * PW'(dyb_ff);
         p_yb_ff <= PW'(wy_ff) * PW'(dxb_ff);
         wx_s2_ff <= wx_ff;
         dxb_s2_ff <= dxb_ff;
         dyb_s2_ff <= dyb_ff;
         bx_s2_ff <= bx_s1_ff;
         by_s2_ff <= by_s1_ff;
         idx_s2_ff <= idx_s1_ff;
         apart_s2_ff <= apart_s1_ff;
         vert_s2_ff <= vert_s1_ff;
      end
   end

   // stage 3: cross products, path select
   logic signed [NW-1:0] tn_ff, td_ff, an_ff;
   logic signed [DW-1:0] dxb_s3_ff, dyb_s3_ff;
   logic signed [COORD_WIDTH-1:0] bx_s3_ff, by_s3_ff;
   logic [INDEX_WIDTH-1:0] idx_s3_ff;
   logic apart_s3_ff, vert_s3_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         if (vert_s2_ff) begin
            tn_ff <= -NW'(wx_s2_ff);
            td_ff <= NW'(dxb_s2_ff);
            an_ff <= '0;
         end else begin
            tn_ff <= NW'(p_wa_ff) - NW'(p_ya_ff);
            td_ff <= NW'(p_ab_ff) - NW'(p_ba_ff);
            an_ff <= NW'(p_wb_ff) - NW'(p_yb_ff);
         end
         dxb_s3_ff <= dxb_s2_ff;
         dyb_s3_ff <= dyb_s2_ff;
         bx_s3_ff <= bx_s2_ff;
         by_s3_ff <= by_s2_ff;
         idx_s3_ff <= idx_s2_ff;
         apart_s3_ff <= apart_s2_ff;
         vert_s3_ff <= vert_s2_ff;
      end
   end

   // stage 4: sign normalize and range test
   logic [NW-1:0] n_ff, d_ff;
   logic signed [DW-1:0] dxb_s4_ff, dyb_s4_ff;
   logic signed [COORD_WIDTH-1:0] bx_s4_ff, by_s4_ff;
   logic [INDEX_WIDTH-1:0] idx_s4_ff;
   logic hit_s4_ff;
   logic signed [NW-1:0] nn, dd, an2, ad2;
   logic ok_t, ok_a;
   always_comb begin
      nn = td_ff[NW-1] ? -tn_ff : tn_ff;
      dd = td_ff[NW-1] ? -td_ff : td_ff;
      an2 = td_ff[NW-1] ? -an_ff : an_ff;
      ad2 = dd;
      ok_t = (td_ff != '0) && !nn[NW-1] && (nn <= dd);
      ok_a = vert_s3_ff || ((td_ff != '0) && !an2[NW-1] && (an2 <= ad2));
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         n_ff <= nn;
         d_ff <= dd;
         hit_s4_ff <= !apart_s3_ff && ok_t && ok_a;
         dxb_s4_ff <= dxb_s3_ff;
         dyb_s4_ff <= dyb_s3_ff;
         bx_s4_ff <= bx_s3_ff;
         by_s4_ff <= by_s3_ff;
         idx_s4_ff <= idx_s3_ff;
      end
   end

   // restoring divider, one quotient bit per stage
   logic [NW:0] rem_ff [DIV_STAGES+1];
   logic [NW-1:0] dv_ff [DIV_STAGES+1];
   logic [FRAC_BITS-1:0] q_ff [DIV_STAGES+1];
   logic eq_ff [DIV_STAGES+1];
   logic hd_ff [DIV_STAGES+1];
   logic signed [DW-1:0] ddx_ff [DIV_STAGES+1];
   logic signed [DW-1:0] ddy_ff [DIV_STAGES+1];
   logic signed [COORD_WIDTH-1:0] dbx_ff [DIV_STAGES+1];
   logic signed [COORD_WIDTH-1:0] dby_ff [DIV_STAGES+1];
   logic [INDEX_WIDTH-1:0] di_ff [DIV_STAGES+1];
   always_comb begin
      rem_ff[0] = {1'b0, n_ff};
      dv_ff[0]  = d_ff;
      q_ff[0]   = '0;
      eq_ff[0]  = (n_ff == d_ff);
      hd_ff[0]  = hit_s4_ff;
      ddx_ff[0] = dxb_s4_ff;
      ddy_ff[0] = dyb_s4_ff;
      dbx_ff[0] = bx_s4_ff;
      dby_ff[0] = by_s4_ff;
      di_ff[0]  = idx_s4_ff;
   end
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      logic [NW:0] sh;
      logic ge;
      always_comb begin
         sh = {rem_ff[s][NW-1:0], 1'b0};
         ge = (sh >= {1'b0, dv_ff[s]});
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[s+1] <= ge ? (sh - {1'b0, dv_ff[s]}) : sh;
            q_ff[s+1]   <= {q_ff[s][FRAC_BITS-2:0], ge};
            dv_ff[s+1]  <= dv_ff[s];
            eq_ff[s+1]  <= eq_ff[s];
            hd_ff[s+1]  <= hd_ff[s];
            ddx_ff[s+1] <= ddx_ff[s];
            ddy_ff[s+1] <= ddy_ff[s];
            dbx_ff[s+1] <= dbx_ff[s];
            dby_ff[s+1] <= dby_ff[s];
            di_ff[s+1]  <= di_ff[s];
         end
      end
   end

   // stage: interpolation products
   logic [FRAC_BITS:0] fr;
   logic signed [LW-1:0] mx_ff, my_ff;
   logic [FRAC_BITS:0] fr_ff;
   logic signed [COORD_WIDTH-1:0] bx_m_ff, by_m_ff;
   logic [INDEX_WIDTH-1:0] idx_m_ff;
   logic hit_m_ff;
   always_comb begin
      fr = eq_ff[DIV_STAGES] ? (FRAC_BITS+1)'(1) << FRAC_BITS
                             : {1'b0, q_ff[DIV_STAGES]};
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         mx_ff <= LW'(signed'({1'b0, fr})) * LW'(ddx_ff[DIV_STAGES]);
         my_ff <= LW'(signed'({1'b0, fr})) * LW'(ddy_ff[DIV_STAGES]);
         fr_ff <= fr;
         bx_m_ff <= dbx_ff[DIV_STAGES];
         by_m_ff <= dby_ff[DIV_STAGES];
         idx_m_ff <= di_ff[DIV_STAGES];
         hit_m_ff <= hd_ff[DIV_STAGES];
      end
   end

   // final stage: sum and miss zeroing
   logic out_hit_ff;
   logic [INDEX_WIDTH-1:0] out_index_ff;
   logic [FRAC_BITS:0] out_fraction_ff;
   logic signed [COORD_WIDTH-1:0] out_x_ff, out_y_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         out_hit_ff      <= hit_m_ff;
         out_index_ff    <= hit_m_ff ? idx_m_ff : '0;
         out_fraction_ff <= hit_m_ff ? fr_ff : '0;
         out_x_ff <= hit_m_ff ?
            bx_m_ff + COORD_WIDTH'(mx_ff >>> FRAC_BITS) : '0;
         out_y_ff <= hit_m_ff ?
            by_m_ff + COORD_WIDTH'(my_ff >>> FRAC_BITS) : '0;
      end
   end

   assign out_valid    = vld_ff[TOTAL-1];
   assign out_hit      = out_hit_ff;
   assign out_index    = out_index_ff;
   assign out_fraction = out_fraction_ff;
   assign out_x        = out_x_ff;
   assign out_y        = out_y_ff;
endmodule

[design/segment_line_intersection.sv]
// segment_line_intersection
// tests each streamed polyline segment against one query segment
// csr channel: csr_index 0..3 sets query start x, start y, end x, end y (signed
// fixed point); the user writes indexes only while the block is idle, unchecked
// req channel: tdata = {second_y, second_x, first_y, first_x, segment_number}
// rsp channel: tdata = {cross_y, cross_x, fraction, hit_segment}, tuser = hit
// one result per request; misses carry zeros in every data field
// stages from req transfer to rsp_tvalid: box test, products, cross products,
// sign fix, one stage per quotient bit of the restoring divider,
// interpolation product, final sum
// throughput: one segment per cycle when not stalled, the pipeline fully occupied
// rsp_tready low while rsp_tvalid is high freezes the whole pipeline;
// req_tready follows it, so nothing is dropped or repeated
// reset clears the stage valid bits and the query registers to zero
module segment_line_intersection #(
   parameter int unsigned COORD_WIDTH = sli_pkg::COORD_WIDTH_DEF,
   parameter int unsigned FRAC_BITS   = sli_pkg::FRAC_BITS_DEF,
   parameter int unsigned INDEX_WIDTH = sli_pkg::INDEX_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [sli_pkg::CSR_ADDR_WIDTH-1:0] csr_index,
   input  logic [COORD_WIDTH-1:0] csr_data,
   input  logic req_tvalid,
   output logic req_tready,
   // segment_number, first_x, first_y, second_x, second_y
   input  logic [((INDEX_WIDTH+4*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // hit_segment, fraction, cross_x, cross_y
   output logic [((INDEX_WIDTH+FRAC_BITS+1+2*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // hit
   output logic rsp_tuser
);
   import sli_pkg::*;

   localparam int unsigned OW = INDEX_WIDTH + FRAC_BITS + 1 + 2 * COORD_WIDTH;
   localparam int unsigned OB = ((OW + 7) / 8) * 8;

   logic signed [COORD_WIDTH-1:0] qx0_ff, qy0_ff, qx1_ff, qy1_ff;
   logic advance;
   logic [INDEX_WIDTH-1:0] o_idx;
   logic [FRAC_BITS:0] o_fr;
   logic signed [COORD_WIDTH-1:0] o_x, o_y;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         qx0_ff <= '0;
         qy0_ff <= '0;
         qx1_ff <= '0;
         qy1_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            REG_START_X: qx0_ff <= csr_data;
            REG_START_Y: qy0_ff <= csr_data;
            REG_END_X:   qx1_ff <= csr_data;
            REG_END_Y:   qy1_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign advance    = rsp_tready || !rsp_tvalid;
   assign req_tready = advance;

   sli_core #(
      .COORD_WIDTH(COORD_WIDTH),
      .FRAC_BITS(FRAC_BITS),
      .INDEX_WIDTH(INDEX_WIDTH)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .advance(advance),
      .in_valid(req_tvalid),
      .in_index(req_tdata[INDEX_WIDTH-1:0]),
      .in_x0(req_tdata[INDEX_WIDTH +: COORD_WIDTH]),
      .in_y0(req_tdata[INDEX_WIDTH+COORD_WIDTH +: COORD_WIDTH]),
      .in_x1(req_tdata[INDEX_WIDTH+2*COORD_WIDTH +: COORD_WIDTH]),
      .in_y1(req_tdata[INDEX_WIDTH+3*COORD_WIDTH +: COORD_WIDTH]),
      .q_x0(qx0_ff),
      .q_y0(qy0_ff),
      .q_x1(qx1_ff),
      .q_y1(qy1_ff),
      .out_valid(rsp_tvalid),
      .out_hit(rsp_tuser),
      .out_index(o_idx),
      .out_fraction(o_fr),
      .out_x(o_x),
      .out_y(o_y)
   );

   assign rsp_tdata = OB'({o_y, o_x, o_fr, o_idx});
endmodule

[design/sli_checker.sv]
module sli_checker #(
   parameter int unsigned COORD_WIDTH = sli_pkg::COORD_WIDTH_DEF,
   parameter int unsigned FRAC_BITS   = sli_pkg::FRAC_BITS_DEF,
   parameter int unsigned INDEX_WIDTH = sli_pkg::INDEX_WIDTH_DEF
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic rsp_tuser,
   input logic [((INDEX_WIDTH+FRAC_BITS+1+2*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp changed while stalled");
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("req accepted while stalled");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("miss with data");
   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser && rsp_tdata[INDEX_WIDTH+FRAC_BITS] |->
         rsp_tdata[INDEX_WIDTH +: FRAC_BITS] == '0)
      else $error("fraction above one");
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("valid after reset");
endmodule

bind segment_line_intersection sli_checker #(
   .COORD_WIDTH(COORD_WIDTH),
   .FRAC_BITS(FRAC_BITS),
   .INDEX_WIDTH(INDEX_WIDTH)
) u_sli_checker (
   .clock(clock),
   .reset(reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tuser(rsp_tuser),
   .rsp_tdata(rsp_tdata)
);

[tb/sv/testbench.sv]
module testbench;
   import sli_pkg::*;

   localparam int COORD_W = 32;
   localparam int FRAC_W = 16;
   localparam int INDEX_W = 16;
   localparam int REQ_W = ((INDEX_W + 4 * COORD_W + 7) / 8) * 8;
   localparam int RSP_W = ((INDEX_W + FRAC_W + 1 + 2 * COORD_W + 7) / 8) * 8;
   localparam longint VERT_LIMIT = ((64'sd1 << FRAC_W) + 9999) / 10000;
   localparam int LATENCY = FRAC_W + 6;

   typedef logic signed [127:0] wide_type;

   typedef struct packed {
      logic hit;
      logic [INDEX_W-1:0] segment;
      logic [FRAC_W:0] fraction;
      logic [COORD_W-1:0] cross_x;
      logic [COORD_W-1:0] cross_y;
   } crossing_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_ADDR_WIDTH-1:0] csr_index = '0;
   logic [COORD_W-1:0] csr_data = '0;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;
   logic rsp_tuser;

   longint query_reg [4];
   crossing_type pending_crossings [$];
   int mismatches = 0;
   int hits_seen = 0;
   int misses_seen = 0;
   int sent_count = 0;
   bit quiet = 0;
   int hold_left = 0;

   segment_line_intersection dut (.*);

   always #10 clock = ~clock;

   function automatic bit boxes_apart(longint a0, longint a1, longint b0, longint b1);
      longint amin, amax, bmin, bmax;
      amin = a0 < a1 ? a0 : a1;
      amax = a0 < a1 ? a1 : a0;
      bmin = b0 < b1 ? b0 : b1;
      bmax = b0 < b1 ? b1 : b0;
      return bmin > amax || bmax < amin;
   endfunction

   function automatic bit ratio_in_unit(inout wide_type n, inout wide_type d);
      if (d == 0) return 0;
      if (d < 0) begin
         n = -n;
         d = -d;
      end
      if (n < 0) return 0;
      return n <= d;
   endfunction

   function automatic crossing_type predict_crossing(logic [INDEX_W-1:0] idx,
         logic signed [COORD_W-1:0] fx, logic signed [COORD_W-1:0] fy,
         logic signed [COORD_W-1:0] sx, logic signed [COORD_W-1:0] sy);
      longint dxa, dya, dxb, dyb, wx, wy, frac;
      wide_type tn, td, an, ad, px, py;
      crossing_type r;
      r = '0;
      dxa = query_reg[REG_END_X] - query_reg[REG_START_X];
      dya = query_reg[REG_END_Y] - query_reg[REG_START_Y];
      dxb = longint'(sx) - longint'(fx);
      dyb = longint'(sy) - longint'(fy);
      wx = longint'(fx) - query_reg[REG_START_X];
      wy = longint'(fy) - query_reg[REG_START_Y];
      if (boxes_apart(query_reg[REG_START_X], query_reg[REG_END_X], fx, sx) ||
          boxes_apart(query_reg[REG_START_Y], query_reg[REG_END_Y], fy, sy))
         return r;
      if (dxa > -VERT_LIMIT && dxa < VERT_LIMIT) begin
         tn = -wide_type'(wx);
         td = wide_type'(dxb);
         if (!ratio_in_unit(tn, td)) return r;
      end else begin
         td = wide_type'(dxa) * wide_type'(dyb) - wide_type'(dya) * wide_type'(dxb);
         tn = wide_type'(wx) * wide_type'(dya) - wide_type'(wy) * wide_type'(dxa);
         an = wide_type'(wx) * wide_type'(dyb) - wide_type'(wy) * wide_type'(dxb);
         ad = td;
         if (!ratio_in_unit(tn, td)) return r;
         if (!ratio_in_unit(an, ad)) return r;
      end
      frac = (tn == td) ? (64'sd1 << FRAC_W) : longint'((tn <<< FRAC_W) / td);
      px = (wide_type'(frac) * wide_type'(dxb)) >>> FRAC_W;
      py = (wide_type'(frac) * wide_type'(dyb)) >>> FRAC_W;
      r.hit = 1;
      r.segment = idx;
      r.fraction = frac[FRAC_W:0];
      r.cross_x = COORD_W'(longint'(fx) + longint'(px));
      r.cross_y = COORD_W'(longint'(fy) + longint'(py));
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      mismatches++;
      $display("mismatch %s: got %0h expected %0h", what, got, want);
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_tready <= quiet || ($urandom_range(0, 99) >= 11);
      end
   end

   always @(posedge clock) begin
      crossing_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata[15:0], rsp_tdata[32:16], rsp_tdata[64:33],
                rsp_tdata[96:65]};
         if (got.hit) hits_seen++; else misses_seen++;
         if (pending_crossings.size() == 0) begin
            report_mismatch("unexpected transfer, hit", got.hit, 0);
         end else begin
            want = pending_crossings.pop_front();
            if (got.hit != want.hit) report_mismatch("hit", got.hit, want.hit);
            if (got.segment != want.segment)
               report_mismatch("hit_segment", got.segment, want.segment);
            if (got.fraction != want.fraction)
               report_mismatch("fraction", got.fraction, want.fraction);
            if (got.cross_x != want.cross_x)
               report_mismatch("cross_x", got.cross_x, want.cross_x);
            if (got.cross_y != want.cross_y)
               report_mismatch("cross_y", got.cross_y, want.cross_y);
         end
      end
   end

   task automatic send_segment(logic [INDEX_W-1:0] idx, longint fx, longint fy,
         longint sx, longint sy);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 99) < 11) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {COORD_W'(sy), COORD_W'(sx), COORD_W'(fy), COORD_W'(fx), idx};
      do @(posedge clock); while (!req_tready);
      pending_crossings = {pending_crossings,
                           predict_crossing(idx, COORD_W'(fx), COORD_W'(fy),
                                            COORD_W'(sx), COORD_W'(sy))};
      sent_count++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 0;
      while (pending_crossings.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_query(csr_index_type idx, longint value);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= COORD_W'(value);
      do @(posedge clock); while (!csr_ready);
      query_reg[idx] = longint'($signed(COORD_W'(value)));
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic set_query(longint x0, longint y0, longint x1, longint y1);
      wait_drained();
      write_query(REG_START_X, x0);
      write_query(REG_START_Y, y0);
      write_query(REG_END_X, x1);
      write_query(REG_END_Y, y1);
   endtask

   function automatic longint rand_coord(int span_bits);
      return $signed(COORD_W'($urandom)) >>> (COORD_W - span_bits);
   endfunction

   // mostly segments built across the query line, some near it, some noise
   task automatic send_random_segment();
      longint px, py, dx, dy, a, b;
      int pick, t;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         send_segment(INDEX_W'($urandom), $signed(COORD_W'($urandom)),
                      $signed(COORD_W'($urandom)),
                      $signed(COORD_W'($urandom)), $signed(COORD_W'($urandom)));
      end else begin
         t = $urandom_range(0, 65536);
         px = query_reg[REG_START_X] +
              ((query_reg[REG_END_X] - query_reg[REG_START_X]) * t >>> 16);
         py = query_reg[REG_START_Y] +
              ((query_reg[REG_END_Y] - query_reg[REG_START_Y]) * t >>> 16);
         dx = rand_coord($urandom_range(2, 24));
         dy = rand_coord($urandom_range(2, 24));
         if ($urandom_range(0, 9) == 0) dx = 0;
         a = $urandom_range(0, 3);
         b = $urandom_range(0, 3);
         if (pick < 40) begin
            px += rand_coord(12);
            py += rand_coord(12);
         end
         if ($urandom_range(0, 1)) send_segment(INDEX_W'($urandom), px - dx * a,
                                                py - dy * a, px + dx * b, py + dy * b);
         else send_segment(INDEX_W'($urandom), px + dx * b, py + dy * b,
                           px - dx * a, py - dy * a);
      end
   endtask

   task automatic test_reset_query();
      send_segment(16'h0001, -65536, -65536, 65536, 65536);
      send_segment(16'h0002, 0, 0, 65536, 0);
      send_segment(16'h0003, 65536, 65536, 131072, 131072);
   endtask

   task automatic test_directed();
      set_query(0, 0, 10 << 16, 0);
      send_segment(16'h0000, 5 << 16, -(1 << 16), 5 << 16, 1 << 16);
      send_segment(16'hffff, 3 << 16, 0, 4 << 16, 2 << 16);
      send_segment(16'h1234, 3 << 16, -(2 << 16), 4 << 16, 0);
      send_segment(16'h0010, 0, 1 << 16, 10 << 16, 1 << 16);
      send_segment(16'h0011, 2 << 16, 0, 8 << 16, 0);
      send_segment(16'h0012, 11 << 16, -(1 << 16), 12 << 16, 1 << 16);
      send_segment(16'h0013, 10 << 16, -(1 << 16), 10 << 16, 1 << 16);
      send_segment(16'h0014, 'h80000000 - 64'sh100000000, 'h80000000 - 64'sh100000000,
                   'h7fffffff, 'h7fffffff);
      set_query('h80000000 - 64'sh100000000, 'h80000000 - 64'sh100000000,
                'h7fffffff, 'h7fffffff);
      send_segment(16'h0020, 'h80000000 - 64'sh100000000, 'h7fffffff,
                   'h7fffffff, 'h80000000 - 64'sh100000000);
      send_segment(16'h0021, 0, 'h7fffffff, 'h7fffffff, 0);
      send_segment(16'h0022, 1, 0, 0, 1);
   endtask

   task automatic test_near_vertical();
      longint dxs [4] = '{0, VERT_LIMIT - 1, -(VERT_LIMIT - 1), VERT_LIMIT};
      foreach (dxs[i]) begin
         set_query(1 << 16, -(4 << 16), (1 << 16) + dxs[i], 4 << 16);
         send_segment(INDEX_W'(16'h0100 + i), 0, 0, 2 << 16, 1 << 16);
         send_segment(INDEX_W'(16'h0200 + i), 1 << 16, 0, 1 << 16, 1 << 16);
         send_segment(INDEX_W'(16'h0300 + i), 2 << 16, 2 << 16, 1 << 16, 2 << 16);
         repeat (20) send_random_segment();
      end
   endtask

   task automatic test_random_queries();
      int span;
      for (int q = 0; q < 5; q++) begin
         span = (q == 4) ? 32 : $urandom_range(8, 28);
         set_query(rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span));
         if (q == 1) quiet = 1;
         repeat (100) send_random_segment();
         quiet = 0;
      end
   endtask

   task automatic test_output_stall();
      set_query(-(50 << 16), -(20 << 16), 50 << 16, 30 << 16);
      @(negedge clock);
      hold_left = 300;
      repeat (60) send_random_segment();
      wait_drained();
      repeat (40) send_random_segment();
   endtask

   initial begin
      #(20 * 400000);
      $display("segment_line_intersection test failed");
      $finish;
   end

   initial begin
      query_reg = '{0, 0, 0, 0};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_reset_query();
      test_directed();
      test_near_vertical();
      test_random_queries();
      test_output_stall();
      wait_drained();
      $display("sent %0d segments against several query settings incl. near vertical,",
               sent_count);
      $display("full range and a long output stall: %0d hits, %0d misses",
               hits_seen, misses_seen);
      if (mismatches == 0) begin
         $display("segment_line_intersection test passed");
      end else begin
         $display("segment_line_intersection test failed");
      end
      $finish;
   end
endmodule
